// ----- rtl/core/ffd_pkg.sv -----
package ffd_pkg;

  localparam int ID_FIELD_BYTES     = 32;
  localparam int TOKEN_FIELD_BYTES  = 32;
  localparam int NUM_FIELD_BYTES    = 4;
  localparam int PAYLOAD_COUNT_BITS = 24;

  localparam int FC_W  = 6;
  localparam int OFS_W = 24;
  localparam int MAX_W = 24;

  localparam logic [23:0] MAX_PAYLOAD_RESET = 24'd65536;

  localparam logic [7:0] SYNC1_BYTE = 8'h55;
  localparam logic [7:0] SYNC2_BYTE = 8'hAA;
  localparam logic [7:0] TRAIL1_BYTE = 8'hCC;
  localparam logic [7:0] TRAIL2_BYTE = 8'h33;

  localparam logic FUNC_DATA    = 1'b0;
  localparam logic FUNC_RESTART = 1'b1;

  typedef enum logic [3:0] {
    PH_HUNT     = 4'd0,
    PH_SYNC2    = 4'd1,
    PH_ID       = 4'd2,
    PH_TOKEN    = 4'd3,
    PH_TIME     = 4'd4,
    PH_LENGTH   = 4'd5,
    PH_PAYLOAD  = 4'd6,
    PH_TRAIL1   = 4'd7,
    PH_TRAIL2   = 4'd8,
    PH_COMPLETE = 4'd9,
    PH_ERROR    = 4'd10
  } phase_t;

  typedef enum logic [2:0] {
    KIND_IGNORED = 3'd0,
    KIND_SYNC    = 3'd1,
    KIND_ID      = 3'd2,
    KIND_TOKEN   = 3'd3,
    KIND_TIME    = 3'd4,
    KIND_LENGTH  = 3'd5,
    KIND_PAYLOAD = 3'd6,
    KIND_TRAILER = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ERR_NONE       = 2'd0,
    ERR_BAD_LENGTH = 2'd1,
    ERR_BAD_TRAIL1 = 2'd2,
    ERR_BAD_TRAIL2 = 2'd3
  } err_t;

  typedef struct packed {
    logic       func;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       status_phase;
    logic [2:0]       byte_kind;
    logic [7:0]       echo_byte;
    logic [OFS_W-1:0] byte_offset;
    logic             field_last;
    logic [31:0]      timestamp_out;
    logic [31:0]      length_out;
    logic [1:0]       error_cause;
  } out_item_t;

endpackage

// ----- rtl/core/ffd_parser.sv -----
module ffd_parser (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         step,
  input  ffd_pkg::in_item_t            item,
  input  logic                         cfg_we,
  input  logic [ffd_pkg::MAX_W-1:0]    cfg_value,
  output ffd_pkg::out_item_t           result
);

  localparam int PCB = ffd_pkg::PAYLOAD_COUNT_BITS;
  localparam logic [32:0] CNT_LIMIT = 33'((64'd1 << PCB) - 64'd1);

  logic [ffd_pkg::MAX_W-1:0] max_payload;
  ffd_pkg::phase_t           phase, phase_next;
  logic [ffd_pkg::FC_W-1:0]  field_count, field_count_next;
  logic [31:0]               time_accum, time_accum_next;
  logic [31:0]               length_accum, length_accum_next;
  logic [PCB-1:0]            payload_count, payload_count_next;
  ffd_pkg::err_t             error_code, error_code_next;

  logic [ffd_pkg::FC_W-1:0]  fc_inc;
  logic [PCB-1:0]            pc_inc;
  logic [31:0]               len_new;
  logic                      len_bad;
  logic                      id_done;
  logic                      tok_done;
  logic                      num_done;
  logic                      pay_done;
  ffd_pkg::kind_t            kind;
  logic [7:0]                echo;
  logic [ffd_pkg::OFS_W-1:0] offs;
  logic                      last;
  logic [7:0]                b;

  assign b        = item.data_byte;
  assign fc_inc   = field_count + ffd_pkg::FC_W'(1);
  assign pc_inc   = payload_count + PCB'(1);
  assign len_new  = {length_accum[23:0], b};
  assign len_bad  = (len_new == 32'd0) ||
                    (len_new > 32'(max_payload)) ||
                    ({1'b0, len_new} > CNT_LIMIT);
  assign id_done  = (fc_inc >= ffd_pkg::FC_W'(ffd_pkg::ID_FIELD_BYTES));
  assign tok_done = (fc_inc >= ffd_pkg::FC_W'(ffd_pkg::TOKEN_FIELD_BYTES));
  assign num_done = (fc_inc >= ffd_pkg::FC_W'(ffd_pkg::NUM_FIELD_BYTES));
  assign pay_done = (32'(pc_inc) >= length_accum);

  always_comb begin
    phase_next         = phase;
    field_count_next   = field_count;
    time_accum_next    = time_accum;
    length_accum_next  = length_accum;
    payload_count_next = payload_count;
    error_code_next    = error_code;
    if (item.func == ffd_pkg::FUNC_RESTART) begin
      phase_next         = ffd_pkg::PH_HUNT;
      field_count_next   = '0;
      time_accum_next    = '0;
      length_accum_next  = '0;
      payload_count_next = '0;
      error_code_next    = ffd_pkg::ERR_NONE;
    end else begin
      unique case (phase) inside
        ffd_pkg::PH_HUNT: begin
          if (b == ffd_pkg::SYNC1_BYTE) begin
            phase_next = ffd_pkg::PH_SYNC2;
          end
        end
        ffd_pkg::PH_SYNC2: begin
          if (b == ffd_pkg::SYNC2_BYTE) begin
            field_count_next = '0;
            phase_next       = ffd_pkg::PH_ID;
          end else if (b != ffd_pkg::SYNC1_BYTE) begin
            phase_next = ffd_pkg::PH_HUNT;
          end
        end
        ffd_pkg::PH_ID: begin
          field_count_next = fc_inc;
          if (id_done) begin
            field_count_next = '0;
            phase_next       = ffd_pkg::PH_TOKEN;
          end
        end
        ffd_pkg::PH_TOKEN: begin
          field_count_next = fc_inc;
          if (tok_done) begin
            field_count_next = '0;
            time_accum_next  = '0;
            phase_next       = ffd_pkg::PH_TIME;
          end
        end
        ffd_pkg::PH_TIME: begin
          time_accum_next  = {time_accum[23:0], b};
          field_count_next = fc_inc;
          if (num_done) begin
            field_count_next  = '0;
            length_accum_next = '0;
            phase_next        = ffd_pkg::PH_LENGTH;
          end
        end
        ffd_pkg::PH_LENGTH: begin
          length_accum_next = len_new;
          field_count_next  = fc_inc;
          if (num_done) begin
            field_count_next = '0;
            if (len_bad) begin
              phase_next      = ffd_pkg::PH_ERROR;
              error_code_next = ffd_pkg::ERR_BAD_LENGTH;
            end else begin
              payload_count_next = '0;
              phase_next         = ffd_pkg::PH_PAYLOAD;
            end
          end
        end
        ffd_pkg::PH_PAYLOAD: begin
          payload_count_next = pc_inc;
          if (pay_done) begin
            phase_next = ffd_pkg::PH_TRAIL1;
          end
        end
        ffd_pkg::PH_TRAIL1: begin
          if (b == ffd_pkg::TRAIL1_BYTE) begin
            phase_next = ffd_pkg::PH_TRAIL2;
          end else begin
            phase_next      = ffd_pkg::PH_ERROR;
            error_code_next = ffd_pkg::ERR_BAD_TRAIL1;
          end
        end
        ffd_pkg::PH_TRAIL2: begin
          if (b == ffd_pkg::TRAIL2_BYTE) begin
            phase_next = ffd_pkg::PH_COMPLETE;
          end else begin
            phase_next      = ffd_pkg::PH_ERROR;
            error_code_next = ffd_pkg::ERR_BAD_TRAIL2;
          end
        end
        ffd_pkg::PH_COMPLETE, ffd_pkg::PH_ERROR: begin
        end
        default: begin
          phase_next = ffd_pkg::PH_ERROR;
        end
      endcase
    end
  end

  always_comb begin
    kind = ffd_pkg::KIND_IGNORED;
    echo = 8'd0;
    offs = '0;
    last = 1'b0;
    if (item.func != ffd_pkg::FUNC_RESTART) begin
      unique case (phase) inside
        ffd_pkg::PH_HUNT: begin
          if (b == ffd_pkg::SYNC1_BYTE) begin
            kind = ffd_pkg::KIND_SYNC;
            echo = b;
          end
        end
        ffd_pkg::PH_SYNC2: begin
          if (b == ffd_pkg::SYNC2_BYTE) begin
            kind = ffd_pkg::KIND_SYNC;
            echo = b;
            offs = ffd_pkg::OFS_W'(1);
            last = 1'b1;
          end else if (b == ffd_pkg::SYNC1_BYTE) begin
            kind = ffd_pkg::KIND_SYNC;
            echo = b;
          end
        end
        ffd_pkg::PH_ID: begin
          kind = ffd_pkg::KIND_ID;
          echo = b;
          offs = ffd_pkg::OFS_W'(field_count);
          last = id_done;
        end
        ffd_pkg::PH_TOKEN: begin
          kind = ffd_pkg::KIND_TOKEN;
          echo = b;
          offs = ffd_pkg::OFS_W'(field_count);
          last = tok_done;
        end
        ffd_pkg::PH_TIME: begin
          kind = ffd_pkg::KIND_TIME;
          echo = b;
          offs = ffd_pkg::OFS_W'(field_count);
          last = num_done;
        end
        ffd_pkg::PH_LENGTH: begin
          kind = ffd_pkg::KIND_LENGTH;
          echo = b;
          offs = ffd_pkg::OFS_W'(field_count);
          last = num_done;
        end
        ffd_pkg::PH_PAYLOAD: begin
          kind = ffd_pkg::KIND_PAYLOAD;
          echo = b;
          offs = ffd_pkg::OFS_W'(payload_count);
          last = pay_done;
        end
        ffd_pkg::PH_TRAIL1: begin
          kind = ffd_pkg::KIND_TRAILER;
          echo = b;
        end
        ffd_pkg::PH_TRAIL2: begin
          kind = ffd_pkg::KIND_TRAILER;
          echo = b;
          offs = ffd_pkg::OFS_W'(1);
          last = 1'b1;
        end
        default: begin
        end
      endcase
    end
    result.status_phase  = phase_next;
    result.byte_kind     = kind;
    result.echo_byte     = echo;
    result.byte_offset   = offs;
    result.field_last    = last;
    result.timestamp_out = time_accum_next;
    result.length_out    = length_accum_next;
    result.error_cause   = error_code_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      max_payload   <= ffd_pkg::MAX_PAYLOAD_RESET;
      phase         <= ffd_pkg::PH_HUNT;
      field_count   <= '0;
      time_accum    <= '0;
      length_accum  <= '0;
      payload_count <= '0;
      error_code    <= ffd_pkg::ERR_NONE;
    end else begin
      if (cfg_we) begin
        max_payload <= cfg_value;
      end
      if (step) begin
        phase         <= phase_next;
        field_count   <= field_count_next;
        time_accum    <= time_accum_next;
        length_accum  <= length_accum_next;
        payload_count <= payload_count_next;
        error_code    <= error_code_next;
      end
    end
  end

endmodule

// ----- rtl/core/ffd_skid.sv -----
module ffd_skid (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  ffd_pkg::out_item_t in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output ffd_pkg::out_item_t out_data
);

  ffd_pkg::out_item_t slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  logic       pop;

  assign in_ready  = (count != 2'd2);
  assign out_valid = (count != 2'd0);
  assign out_data  = slot[rd_ptr];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= in_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      if (push && !pop) begin
        count <= count + 2'd1;
      end else if (pop && !push) begin
        count <= count - 2'd1;
      end
    end
  end

endmodule

// ----- rtl/core/fixed_frame_deframer.sv -----
// Fixed-frame deframer: sync 0x55 0xAA, id, token, timestamp, length,
// payload, trailer 0xCC 0x33.
// Input channel in_valid/in_ready/in_item: one transaction is a data byte
// or a restart (func). Each input transaction yields exactly one result
// transaction on out_valid/out_ready/out_item, in order.
// Config channel cfg_valid/cfg_ready/cfg_data writes max_payload_bytes;
// cfg_ready is always high. Write it only while the block is idle.
// Results are registered: out_valid rises in the cycle after a transaction.
// Throughput: one byte per cycle unless stalled; the parse step is a single
// combinational pass from the state registers into a two-entry output buffer.
// Stall: the buffer holds two results; in_ready drops only when both are
// waiting, and rises in the cycle after the receiver takes one.
// Reset (rst, synchronous): parser to hunting, accumulators and error
// cleared, output buffer emptied, max_payload_bytes back to 65536.
module fixed_frame_deframer (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  ffd_pkg::in_item_t         in_item,
  output logic                      out_valid,
  input  logic                      out_ready,
  output ffd_pkg::out_item_t        out_item,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [ffd_pkg::MAX_W-1:0] cfg_data
);

  ffd_pkg::out_item_t result;
  logic               step;

  assign cfg_ready = 1'b1;
  assign step      = in_valid && in_ready;

  ffd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .step      (step),
    .item      (in_item),
    .cfg_we    (cfg_valid && cfg_ready),
    .cfg_value (cfg_data),
    .result    (result)
  );

  ffd_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (result),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_item)
  );

endmodule

// ----- rtl/core/ffd_checker.sv -----
module ffd_checker (
  input logic                      clk,
  input logic                      rst,
  input logic                      in_valid,
  input logic                      in_ready,
  input logic                      out_valid,
  input logic                      out_ready,
  input ffd_pkg::out_item_t        out_item
);

  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("buffer not empty after reset");

  a_one_cycle: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready && !out_valid) |=> out_valid)
    else $error("result missing one cycle after transaction");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_item)))
    else $error("stalled result changed");

  a_ignored_clean: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.byte_kind == ffd_pkg::KIND_IGNORED) |->
      (out_item.echo_byte == 8'd0 && out_item.byte_offset == '0 &&
       !out_item.field_last))
    else $error("ignored byte carries data");

  a_hunt_clear: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_item.status_phase == ffd_pkg::PH_HUNT) |->
      (out_item.timestamp_out == 32'd0 && out_item.length_out == 32'd0 &&
       out_item.error_cause == ffd_pkg::ERR_NONE))
    else $error("hunting with stale frame state");

endmodule

bind fixed_frame_deframer ffd_checker u_ffd_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_item  (out_item)
);
